[rtl/hdm_pkg.sv]
// Shared types, constants and helpers for the Hamming descriptor matcher.
// No dependencies.
package hdm_pkg;

  localparam int DESC_W = 256;
  localparam int DIST_W = 9;

  localparam logic [DIST_W-1:0] DIST_NONE = 9'd256;
  localparam logic [DIST_W-1:0] THR_RESET = 9'd24;

  // drain count at which the scan leaves the drain state with the best entry final
  localparam logic [1:0] PIPE_DRAIN = 2'd3;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_QUERY = 2'd2
  } func_t;

  typedef struct packed {
    logic wr_en;
    logic wr_desc;
    logic vbit;
  } hdm_wr_ctl_t;

  typedef struct packed {
    logic              vld;
    logic              hit;
    logic [DIST_W-1:0] dist_val;
  } hdm_res_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

[rtl/hdm_if.sv]
// Item channels of the Hamming descriptor matcher: query/load input, match result.
// No dependencies.
interface hdm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  entry_level;
  logic [8:0]  entry_slot;
  logic [8:0]  query_tag;
  logic [63:0] desc_word0;
  logic [63:0] desc_word1;
  logic [63:0] desc_word2;
  logic [63:0] desc_word3;

  modport source (
    output valid, func, entry_level, entry_slot, query_tag,
           desc_word0, desc_word1, desc_word2, desc_word3,
    input  ready
  );
  modport sink (
    input  valid, func, entry_level, entry_slot, query_tag,
           desc_word0, desc_word1, desc_word2, desc_word3,
    output ready
  );
endinterface

interface hdm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [8:0] echo_tag;
  logic [1:0] best_level;
  logic [8:0] best_slot;
  logic [8:0] best_distance;

  modport source (
    output valid, matched, echo_tag, best_level, best_slot, best_distance,
    input  ready
  );
  modport sink (
    input  valid, matched, echo_tag, best_level, best_slot, best_distance,
    output ready
  );
endinterface

[rtl/hdm_store.sv]
// Descriptor memory and entry valid memory, one write and one registered read port.
// Depends on hdm_pkg.
module hdm_store import hdm_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  hdm_wr_ctl_t       wr_ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DESC_W-1:0] wr_desc,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DESC_W-1:0] rd_desc,
  output logic              rd_vbit
);

  logic [DESC_W-1:0] desc_mem [DEPTH];
  logic              vbit_mem [DEPTH];

  logic [DESC_W-1:0] rd_desc_r;
  logic              rd_vbit_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_en && wr_ctl.wr_desc) begin
      desc_mem[wr_addr] <= wr_desc;
    end
    if (rd_en) begin
      rd_desc_r <= desc_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_en) begin
      vbit_mem[wr_addr] <= wr_ctl.vbit;
    end
    if (rd_en) begin
      rd_vbit_r <= vbit_mem[rd_addr];
    end
  end

  assign rd_desc = rd_desc_r;
  assign rd_vbit = rd_vbit_r;

endmodule

[rtl/hdm_dist.sv]
// Three-stage Hamming distance pipeline: byte counts, group sums, total.
// Depends on hdm_pkg.
module hdm_dist import hdm_pkg::*; #(
  parameter int TAG_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic              in_hit,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic [DESC_W-1:0] stored,
  input  logic [DESC_W-1:0] query,
  output hdm_res_t          res,
  output logic [TAG_W-1:0]  res_tag
);

  localparam int NBYTES = DESC_W / 8;
  localparam int NGRP   = 4;
  localparam int GBYTES = NBYTES / NGRP;

  logic [DESC_W-1:0] x;
  logic [3:0]        bc_r [NBYTES];
  logic [6:0]        grp [NGRP];
  logic [6:0]        grp_r [NGRP];
  logic [DIST_W-1:0] dist_r;
  logic              v1_r, v2_r, v3_r;
  logic              h1_r, h2_r, h3_r;
  logic [TAG_W-1:0]  t1_r, t2_r, t3_r;

  assign x = stored ^ query;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp[g] = '0;
      for (int k = 0; k < GBYTES; k++) begin
        grp[g] = grp[g] + 7'(bc_r[g*GBYTES + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBYTES; b++) begin
      bc_r[b] <= popcnt8(x[8*b +: 8]);
    end
    h1_r <= in_hit;
    t1_r <= in_tag;
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp[g];
    end
    h2_r   <= h1_r;
    t2_r   <= t1_r;
    dist_r <= DIST_W'(grp_r[0]) + DIST_W'(grp_r[1]) + DIST_W'(grp_r[2]) + DIST_W'(grp_r[3]);
    h3_r   <= h2_r;
    t3_r   <= t2_r;
  end

  assign res.vld      = v3_r;
  assign res.hit      = h3_r;
  assign res.dist_val = dist_r;
  assign res_tag      = t3_r;

endmodule

[rtl/hamming_descriptor_matcher_top.sv]
// Top level of the Hamming descriptor matcher: control, threshold register, result register.
// Depends on hdm_pkg, hdm_if, hdm_store, hdm_dist.
//
// Keeps NUM_LEVELS x ENTRIES_PER_LEVEL 256-bit descriptors in a single-port-read memory with
// a valid memory beside it. A query reads one stored entry per cycle through the single store
// read port, then drains the distance pipeline and hands the result over. A clear sweeps
// the valid memory one entry per cycle, and the same sweep runs after reset before the
// first item is accepted. Threshold writes are taken at any time. A finished result waits
// in the output register while the next item is accepted.
module hamming_descriptor_matcher_top import hdm_pkg::*; #(
  parameter int NUM_LEVELS        = 4,
  parameter int ENTRIES_PER_LEVEL = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  hdm_in_if.sink      in_ch,
  hdm_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  localparam int TOTAL = NUM_LEVELS * ENTRIES_PER_LEVEL;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SW    = (ENTRIES_PER_LEVEL > 1) ? $clog2(ENTRIES_PER_LEVEL) : 1;
  localparam int TAG_W = LW + SW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     cnt_r;
  logic [LW-1:0]     lev_r;
  logic [SW-1:0]     slot_r;
  logic [1:0]        dcnt_r;
  logic [DESC_W-1:0] q_r;
  logic [8:0]        tag_r;
  logic [DIST_W-1:0] best_r;
  logic [LW-1:0]     best_lev_r;
  logic [SW-1:0]     best_slot_r;
  logic [8:0]        thr_r;
  logic              iss_vld_r;
  logic [TAG_W-1:0]  iss_tag_r;

  logic              out_vld_r;
  logic              out_matched_r;
  logic [8:0]        out_tag_r;
  logic [1:0]        out_lev_r;
  logic [8:0]        out_slot_r;
  logic [8:0]        out_dist_r;

  hdm_wr_ctl_t       wr_ctl;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     load_addr;
  logic              load_ok;
  logic              clearing;
  logic [DESC_W-1:0] in_desc;
  logic [DESC_W-1:0] rd_desc;
  logic              rd_vbit;
  hdm_res_t          res;
  logic [TAG_W-1:0]  res_tag;

  assign in_desc  = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0};
  assign clearing = (state_r == ST_CLEAR);
  assign load_ok  = (state_r == ST_IDLE) && in_ch.valid && (in_ch.func == FN_LOAD) &&
                    (32'(in_ch.entry_level) < NUM_LEVELS) &&
                    (32'(in_ch.entry_slot) < ENTRIES_PER_LEVEL);
  assign load_addr = AW'(32'(in_ch.entry_level) * ENTRIES_PER_LEVEL + 32'(in_ch.entry_slot));

  assign wr_ctl.wr_en   = clearing || load_ok;
  assign wr_ctl.wr_desc = !clearing;
  assign wr_ctl.vbit    = !clearing;
  assign wr_addr        = clearing ? cnt_r : load_addr;

  hdm_store #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_desc (in_desc),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (cnt_r),
    .rd_desc (rd_desc),
    .rd_vbit (rd_vbit)
  );

  hdm_dist #(
    .TAG_W (TAG_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (iss_vld_r),
    .in_hit  (rd_vbit),
    .in_tag  (iss_tag_r),
    .stored  (rd_desc),
    .query   (q_r),
    .res     (res),
    .res_tag (res_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      iss_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      iss_vld_r <= (state_r == ST_SCAN);
      iss_tag_r <= {lev_r, slot_r};
      if (out_vld_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_vld_r <= 1'b0;
      end
      if (res.vld && res.hit && (res.dist_val < best_r)) begin
        best_r      <= res.dist_val;
        best_lev_r  <= res_tag[TAG_W-1:SW];
        best_slot_r <= res_tag[SW-1:0];
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            case (in_ch.func)
              FN_CLEAR: begin
                cnt_r   <= '0;
                state_r <= ST_CLEAR;
              end
              FN_QUERY: begin
                q_r         <= in_desc;
                tag_r       <= in_ch.query_tag;
                best_r      <= DIST_NONE;
                best_lev_r  <= '0;
                best_slot_r <= '0;
                cnt_r       <= '0;
                lev_r       <= '0;
                slot_r      <= '0;
                state_r     <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_CLEAR: begin
          if (cnt_r == AW'(TOTAL - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (slot_r == SW'(ENTRIES_PER_LEVEL - 1)) begin
            slot_r <= '0;
            lev_r  <= lev_r + 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
          if (cnt_r == AW'(TOTAL - 1)) begin
            dcnt_r  <= '0;
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (dcnt_r == PIPE_DRAIN) begin
            state_r <= ST_DONE;
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_vld_r || out_ch.ready) begin
            out_vld_r     <= 1'b1;
            out_matched_r <= !best_r[DIST_W-1] && (best_r < thr_r);
            out_tag_r     <= tag_r;
            out_lev_r     <= 2'(best_lev_r);
            out_slot_r    <= 9'(best_slot_r);
            out_dist_r    <= best_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_vld_r;
  assign out_ch.matched       = out_matched_r;
  assign out_ch.echo_tag      = out_tag_r;
  assign out_ch.best_level    = out_lev_r;
  assign out_ch.best_slot     = out_slot_r;
  assign out_ch.best_distance = out_dist_r;

`ifndef SYNTHESIS
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |=> (best_r <= $past(best_r)))
    else $error("best distance rose during a scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !wr_ctl.wr_en)
    else $error("store written during a scan");

  a_res_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance result outside a scan");

  a_match_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_matched_r) |-> !out_dist_r[DIST_W-1])
    else $error("match reported without a chosen entry");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_dist_r == DIST_NONE) |-> (out_lev_r == '0 && out_slot_r == '0))
    else $error("no entry chosen but position not zero");
`endif

endmodule
